// ===== hw/rtl/block_matrix_partition_unpacker_defines.svh =====
// Assertion macros shared by the tile unpacker RTL.
// Included by the top level only; no other dependencies.
`ifndef BLOCK_MATRIX_PARTITION_UNPACKER_DEFINES_SVH
`define BLOCK_MATRIX_PARTITION_UNPACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define BMPU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: condition must never hold");
`define BMPU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define BMPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define BMPU_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define BMPU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BMPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bmpu_pkg.sv =====
// Shared constants, result codes and controller/datapath structs of the tile unpacker.
// No dependencies; every other RTL file but the macro header refers to it by scoped names.
package bmpu_pkg;

	localparam int COORD_BITS_DEF    = 40;
	localparam int TILE_DIM_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;
	localparam int MDIM_W     = 40;
	localparam int TS_W       = 16;
	localparam int TIDX_W     = 31;
	localparam int DIM_W      = 32;
	localparam int VAL_W      = 64;
	localparam int KIND_W     = 2;
	localparam int ORG_W      = TIDX_W + TS_W;

	// Shared divider: ceil(cols / ts) needs 41 dividend bits, the grid width 40 divisor bits.
	localparam int DVD_W = MDIM_W + 1;
	localparam int DVS_W = MDIM_W;

	localparam int HDR_BYTES = 9;
	localparam int HDR_CNT_W = 4;
	localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);
	localparam int LANE_W = 3;
	localparam logic [LANE_W-1:0] LANE_LAST = '1;

	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_INDEX  = 2'd3;

	localparam logic [KIND_W-1:0] KIND_ELEM     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BAD_DIMS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TRUNC    = 2'd3;

	typedef struct packed {
		logic                 hdr_wr;
		logic [HDR_CNT_W-1:0] hdr_idx;
		logic                 data_wr;
		logic [LANE_W-1:0]    lane;
		logic                 div_start;
		logic                 div_sel;
		logic                 take_q;
		logic                 clr_q;
		logic                 mul;
		logic                 ext;
		logic                 start_data;
		logic                 advance;
		logic                 load_out;
		logic                 out_elem;
		logic [KIND_W-1:0]    out_kind;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic nbc_zero;
		logic last;
		logic bad_dims;
		logic mismatch;
	} stat_t;

endpackage

// ===== hw/rtl/bmpu_ifs.sv =====
// Valid/ready channel interfaces of the tile unpacker: byte input, result output, config write.
// Depends on bmpu_pkg for field widths.
interface bmpu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, data_byte, final_byte, input ready);
	modport sink (input valid, data_byte, final_byte, output ready);
endinterface

interface bmpu_out_if #(
	parameter int COORD_BITS = bmpu_pkg::COORD_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [bmpu_pkg::KIND_W-1:0]   kind;
	logic [COORD_BITS-1:0]         row_index;
	logic [COORD_BITS-1:0]         col_index;
	logic [bmpu_pkg::VAL_W-1:0]    value_bits;
	logic                          tile_end;

	modport source (output valid, kind, row_index, col_index, value_bits, tile_end,
		input ready);
	modport sink (input valid, kind, row_index, col_index, value_bits, tile_end,
		output ready);
endinterface

interface bmpu_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bmpu_pkg::CFG_IDX_W-1:0]    index;
	logic [bmpu_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bmpu_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the tile grid arithmetic.
// Depends on bmpu_pkg for default widths.
module bmpu_div #(
	parameter int DVD_W = bmpu_pkg::DVD_W,
	parameter int DVS_W = bmpu_pkg::DVS_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DVS_W-1:0];
endmodule

// ===== hw/rtl/bmpu_dp.sv =====
// Datapath of the tile unpacker: config registers, header fields, tile geometry, element
// assembly and the result register. Depends on bmpu_pkg and bmpu_div.
module bmpu_dp #(
	parameter int COORD_BITS    = bmpu_pkg::COORD_BITS_DEF,
	parameter int TILE_DIM_BITS = bmpu_pkg::TILE_DIM_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr,
	input  logic [bmpu_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [bmpu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [7:0]                         data_byte,
	input  bmpu_pkg::cmd_t                     cmd,
	output bmpu_pkg::stat_t                    stat,
	output logic [bmpu_pkg::KIND_W-1:0]        kind,
	output logic [COORD_BITS-1:0]              row_index,
	output logic [COORD_BITS-1:0]              col_index,
	output logic [bmpu_pkg::VAL_W-1:0]         value_bits,
	output logic                               tile_end
);
	localparam int MDIM_W = bmpu_pkg::MDIM_W;
	localparam int TS_W   = bmpu_pkg::TS_W;
	localparam int TIDX_W = bmpu_pkg::TIDX_W;
	localparam int DIM_W  = bmpu_pkg::DIM_W;
	localparam int ORG_W  = bmpu_pkg::ORG_W;
	localparam int DVD_W  = bmpu_pkg::DVD_W;
	localparam int DVS_W  = bmpu_pkg::DVS_W;
	localparam int SHF_W  = bmpu_pkg::VAL_W - 8;

	localparam logic [TS_W-1:0] TS_MASK = (TILE_DIM_BITS >= TS_W) ? {TS_W{1'b1}} :
		TS_W'((64'd1 << TILE_DIM_BITS) - 64'd1);
	localparam logic [MDIM_W-1:0] DIM_MASK = (COORD_BITS >= MDIM_W) ? {MDIM_W{1'b1}} :
		MDIM_W'((64'd1 << COORD_BITS) - 64'd1);

	logic [MDIM_W-1:0]        mrows_q, mcols_q;
	logic [TS_W-1:0]          tsize_q;
	logic [TIDX_W-1:0]        tidx_q;
	logic [DIM_W-1:0]         srows_q, scols_q;
	logic                     transp_q;
	logic [TIDX_W-1:0]        br_q, bc_q;
	logic [ORG_W-1:0]         rs_q, cs_q;
	logic [TS_W-1:0]          er_q, ec_q;
	logic [COORD_BITS-1:0]    row_org_q, col_org_q;
	logic [TILE_DIM_BITS-1:0] lrow_q, lcol_q;
	logic [SHF_W-1:0]         shf_q;

	logic [TS_W-1:0]   ts_m, ts;
	logic [MDIM_W-1:0] rows_m, cols_m;
	logic [DVD_W-1:0]  dvd;
	logic [DVS_W-1:0]  dvs;
	logic [DVD_W-1:0]  div_quo;
	logic [DVS_W-1:0]  div_rem;
	logic              div_busy, div_done;
	logic [ORG_W-1:0]  rs_prod, cs_prod;
	logic              row_done, col_done;

	function automatic logic [TS_W-1:0] exp_dim(input logic [MDIM_W-1:0] total,
		input logic [ORG_W-1:0] org, input logic [TS_W-1:0] edge_len);
		logic [ORG_W-1:0] tot;
		logic [ORG_W-1:0] rest;
		tot  = ORG_W'(total);
		rest = tot - org;
		if (tot <= org) begin
			return '0;
		end
		if (rest < ORG_W'(edge_len)) begin
			return rest[TS_W-1:0];
		end
		return edge_len;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrows_q <= MDIM_W'(1);
			mcols_q <= MDIM_W'(1);
			tsize_q <= TS_W'(4096);
			tidx_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				bmpu_pkg::REG_MATRIX_ROWS: mrows_q <= cfg_data[MDIM_W-1:0];
				bmpu_pkg::REG_MATRIX_COLS: mcols_q <= cfg_data[MDIM_W-1:0];
				bmpu_pkg::REG_TILE_SIZE:   tsize_q <= cfg_data[TS_W-1:0];
				bmpu_pkg::REG_TILE_INDEX:  tidx_q  <= cfg_data[TIDX_W-1:0];
				default: ;
			endcase
		end
	end

	assign ts_m   = tsize_q & TS_MASK;
	assign ts     = (ts_m == '0) ? TS_W'(1) : ts_m;
	assign rows_m = mrows_q & DIM_MASK;
	assign cols_m = mcols_q & DIM_MASK;

	// First pass: grid columns = ceil(cols / ts). Second pass: tile index over grid columns.
	assign dvd = cmd.div_sel ? DVD_W'(tidx_q) :
		DVD_W'(cols_m) + DVD_W'(ts) - DVD_W'(1);
	assign dvs = cmd.div_sel ? div_quo[DVS_W-1:0] : DVS_W'(ts);

	bmpu_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign rs_prod = br_q * ts;
	assign cs_prod = bc_q * ts;

	assign row_done = DIM_W'(lrow_q) + DIM_W'(1) >= srows_q;
	assign col_done = DIM_W'(lcol_q) + DIM_W'(1) >= scols_q;

	always_ff @(posedge clk) begin
		if (cmd.hdr_wr) begin
			if (cmd.hdr_idx == bmpu_pkg::HDR_LAST) begin
				transp_q <= data_byte != 8'd0;
			end else if (!cmd.hdr_idx[2]) begin
				srows_q[{cmd.hdr_idx[1:0], 3'b000} +: 8] <= data_byte;
			end else begin
				scols_q[{cmd.hdr_idx[1:0], 3'b000} +: 8] <= data_byte;
			end
		end
		if (cmd.take_q) begin
			br_q <= div_quo[TIDX_W-1:0];
			bc_q <= div_rem[TIDX_W-1:0];
		end else if (cmd.clr_q) begin
			br_q <= '0;
			bc_q <= '0;
		end
		if (cmd.mul) begin
			rs_q <= rs_prod;
			cs_q <= cs_prod;
		end
		if (cmd.ext) begin
			er_q <= exp_dim(rows_m, rs_q, ts);
			ec_q <= exp_dim(cols_m, cs_q, ts);
		end
		// The top byte of an element goes straight to the result register.
		if (cmd.data_wr && cmd.lane != bmpu_pkg::LANE_LAST) begin
			shf_q[{cmd.lane, 3'b000} +: 8] <= data_byte;
		end
		if (cmd.start_data) begin
			row_org_q <= COORD_BITS'(rs_q);
			col_org_q <= COORD_BITS'(cs_q);
			lrow_q    <= '0;
			lcol_q    <= '0;
		end else if (cmd.advance) begin
			if (transp_q) begin
				if (col_done) begin
					lcol_q <= '0;
					lrow_q <= lrow_q + TILE_DIM_BITS'(1);
				end else begin
					lcol_q <= lcol_q + TILE_DIM_BITS'(1);
				end
			end else begin
				if (row_done) begin
					lrow_q <= '0;
					lcol_q <= lcol_q + TILE_DIM_BITS'(1);
				end else begin
					lrow_q <= lrow_q + TILE_DIM_BITS'(1);
				end
			end
		end
		if (cmd.load_out) begin
			if (cmd.out_elem) begin
				kind       <= bmpu_pkg::KIND_ELEM;
				row_index  <= row_org_q + COORD_BITS'(lrow_q);
				col_index  <= col_org_q + COORD_BITS'(lcol_q);
				value_bits <= {data_byte, shf_q};
				tile_end   <= row_done && col_done;
			end else begin
				kind       <= cmd.out_kind;
				row_index  <= '0;
				col_index  <= '0;
				value_bits <= '0;
				tile_end   <= 1'b1;
			end
		end
	end

	always_comb begin
		stat.div_busy = div_busy;
		stat.div_done = div_done;
		stat.nbc_zero = div_quo == '0;
		stat.last     = row_done && col_done;
		stat.bad_dims = srows_q == '0 || srows_q[DIM_W-1] || scols_q == '0 || scols_q[DIM_W-1];
		stat.mismatch = srows_q != DIM_W'(er_q) || scols_q != DIM_W'(ec_q);
	end
endmodule

// ===== hw/rtl/bmpu_ctrl.sv =====
// Controller of the tile unpacker: header/data/drain sequencing, geometry steps and the
// result-valid flag. Depends on bmpu_pkg; drives bmpu_dp through cmd_t.
module bmpu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_final,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	input  bmpu_pkg::stat_t stat,
	output bmpu_pkg::cmd_t  cmd
);
	localparam logic [2:0] ST_HEADER  = 3'd0;
	localparam logic [2:0] ST_DATA    = 3'd1;
	localparam logic [2:0] ST_DRAIN   = 3'd2;
	localparam logic [2:0] ST_DIV_CNT = 3'd3;
	localparam logic [2:0] ST_DIV_IDX = 3'd4;
	localparam logic [2:0] ST_MUL     = 3'd5;
	localparam logic [2:0] ST_EXT     = 3'd6;
	localparam logic [2:0] ST_CHECK   = 3'd7;

	logic [2:0]                     state_q, state_d;
	logic [bmpu_pkg::HDR_CNT_W-1:0] hc_q, hc_d;
	logic [bmpu_pkg::LANE_W-1:0]    vbc_q, vbc_d;
	logic                           fin_q, fin_d;
	logic                           out_valid_q;
	logic                           slot;
	logic                           acc;

	always_comb begin
		state_d  = state_q;
		hc_d     = hc_q;
		vbc_d    = vbc_q;
		fin_d    = fin_q;
		cmd      = '0;
		slot     = !out_valid_q || out_ready;
		in_ready = slot && (state_q == ST_HEADER || state_q == ST_DATA || state_q == ST_DRAIN);
		acc      = in_valid && in_ready;
		case (state_q)
			ST_HEADER: begin
				if (acc) begin
					cmd.hdr_wr  = 1'b1;
					cmd.hdr_idx = hc_q;
					if (hc_q == bmpu_pkg::HDR_LAST) begin
						hc_d          = '0;
						fin_d         = in_final;
						cmd.div_start = 1'b1;
						state_d       = ST_DIV_CNT;
					end else if (in_final) begin
						hc_d         = '0;
						cmd.load_out = 1'b1;
						cmd.out_kind = bmpu_pkg::KIND_TRUNC;
					end else begin
						hc_d = hc_q + bmpu_pkg::HDR_CNT_W'(1);
					end
				end
			end
			ST_DIV_CNT: begin
				if (stat.div_done) begin
					// A matrix without columns has an empty grid: the tile sits at the origin.
					if (stat.nbc_zero) begin
						cmd.clr_q = 1'b1;
						state_d   = ST_MUL;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = 1'b1;
						state_d       = ST_DIV_IDX;
					end
				end
			end
			ST_DIV_IDX: begin
				if (stat.div_done) begin
					cmd.take_q = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EXT;
			end
			ST_EXT: begin
				cmd.ext = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.bad_dims || stat.mismatch || fin_q) begin
					if (slot) begin
						cmd.load_out = 1'b1;
						cmd.out_kind = stat.bad_dims ? bmpu_pkg::KIND_BAD_DIMS :
							stat.mismatch ? bmpu_pkg::KIND_MISMATCH : bmpu_pkg::KIND_TRUNC;
						state_d = fin_q ? ST_HEADER : ST_DRAIN;
					end
				end else begin
					cmd.start_data = 1'b1;
					vbc_d          = '0;
					state_d        = ST_DATA;
				end
			end
			ST_DATA: begin
				if (acc) begin
					cmd.data_wr = 1'b1;
					cmd.lane    = vbc_q;
					vbc_d       = vbc_q + bmpu_pkg::LANE_W'(1);
					if (vbc_q == bmpu_pkg::LANE_LAST) begin
						cmd.load_out = 1'b1;
						if (in_final && !stat.last) begin
							cmd.out_kind = bmpu_pkg::KIND_TRUNC;
							state_d      = ST_HEADER;
						end else begin
							cmd.out_elem = 1'b1;
							if (stat.last) begin
								state_d = in_final ? ST_HEADER : ST_DRAIN;
							end else begin
								cmd.advance = 1'b1;
							end
						end
					end else if (in_final) begin
						vbc_d        = '0;
						cmd.load_out = 1'b1;
						cmd.out_kind = bmpu_pkg::KIND_TRUNC;
						state_d      = ST_HEADER;
					end
				end
			end
			ST_DRAIN: begin
				if (acc && in_final) begin
					hc_d    = '0;
					state_d = ST_HEADER;
				end
			end
			default: begin
				state_d = ST_HEADER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HEADER;
			hc_q        <= '0;
			vbc_q       <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hc_q    <= hc_d;
			vbc_q   <= vbc_d;
			fin_q   <= fin_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== hw/rtl/block_matrix_partition_unpacker.sv =====
// Matrix tile unpacker: takes one tile's decompressed payload a byte at a time and emits
// elements with global coordinates, or one error item that ends the tile.
// Depends on bmpu_pkg, the channel interfaces, bmpu_ctrl, bmpu_dp and the macro header.
// Configuration is written through cfg (index 0 rows, 1 cols, 2 tile size, 3 tile index);
// the user must do so only while the block is idle, which the block does not enforce. cfg
// is always ready and the registers reset to 1, 1, 4096, 0. data_in carries data_byte and
// final_byte; final_byte marks the tile's last byte. data_out carries kind, row_index,
// col_index, value_bits and tile_end. The nine header bytes are taken one per cycle. After
// the ninth, data_in is held off while the tile origin takes two passes through one shared
// restoring divider, one step per dividend bit, then the multiply, clip and check states;
// a matrix without columns skips the second pass. Data bytes are taken one per cycle; an
// element appears in the output register the cycle after its eighth byte. Errors (bad or
// mismatching dimensions, truncation) are one item with tile_end set; a truncated tile is
// reported at its final byte, after any elements already sent, and the consumer drops the
// tile. Bytes after the tile's end are swallowed up to the final byte. When data_out stalls,
// the result waits in its register and data_in is held off until the register is free.
// Reset returns to the header phase with no result pending.
`include "block_matrix_partition_unpacker_defines.svh"
module block_matrix_partition_unpacker #(
	parameter int COORD_BITS    = bmpu_pkg::COORD_BITS_DEF,
	parameter int TILE_DIM_BITS = bmpu_pkg::TILE_DIM_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bmpu_in_if.sink      data_in,
	bmpu_out_if.source   data_out,
	bmpu_cfg_if.sink     cfg
);
	bmpu_pkg::cmd_t  cmd;
	bmpu_pkg::stat_t stat;

	assign cfg.ready = 1'b1;

	bmpu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (data_in.valid),
		.in_final (data_in.final_byte),
		.in_ready (data_in.ready),
		.out_ready(data_out.ready),
		.out_valid(data_out.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	bmpu_dp #(
		.COORD_BITS   (COORD_BITS),
		.TILE_DIM_BITS(TILE_DIM_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.data_byte (data_in.data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (data_out.kind),
		.row_index (data_out.row_index),
		.col_index (data_out.col_index),
		.value_bits(data_out.value_bits),
		.tile_end  (data_out.tile_end)
	);

	`BMPU_ASSERT_NEVER(a_ready_while_div, clk, arst_n, data_in.ready && stat.div_busy)
	`BMPU_ASSERT_NEXT(a_stall_after_div_start, clk, arst_n, cmd.div_start, !data_in.ready)
	`BMPU_ASSERT_IMPL(a_no_result_overwrite, clk, arst_n,
		cmd.load_out, !data_out.valid || data_out.ready)
	`BMPU_ASSERT_IMPL(a_error_item_clean, clk, arst_n,
		data_out.valid && data_out.kind != bmpu_pkg::KIND_ELEM,
		data_out.tile_end && data_out.row_index == '0 && data_out.value_bits == '0)
endmodule

// ===== tb/block_matrix_partition_unpacker_test.sv =====
// Self-checking testbench for the matrix tile unpacker: drives tile payload bytes and
// configuration writes, predicts every element or error item and checks it in order.
// Depends on bmpu_pkg, the channel interfaces in bmpu_ifs.sv and the block's RTL.
module block_matrix_partition_unpacker_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bmpu_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int unsigned RANDOM_ITEMS = 300;
	localparam int unsigned SETTLE_CYCLES = 150;
	localparam int unsigned DRAIN_LIMIT = 50000;
	localparam int unsigned WATCHDOG_LIMIT = 1000000;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_DRAIN  = 2'd2
	} unpack_phase_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [CW-1:0]     row;
		logic [CW-1:0]     col;
		logic [VAL_W-1:0]  value;
		logic              tile_end;
	} tile_result_t;

	logic clk;
	logic arst_n;

	bmpu_in_if                       in_ch();
	bmpu_out_if #(.COORD_BITS(CW))   out_ch();
	bmpu_cfg_if                      cfg_ch();

	block_matrix_partition_unpacker #(
		.COORD_BITS(CW),
		.TILE_DIM_BITS(TILE_DIM_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_in(in_ch),
		.data_out(out_ch),
		.cfg(cfg_ch)
	);

	// Shadow of the configuration registers.
	logic [MDIM_W-1:0] cfg_rows = 40'd1;
	logic [MDIM_W-1:0] cfg_cols = 40'd1;
	logic [TS_W-1:0]   cfg_tsize = 16'd4096;
	logic [TIDX_W-1:0] cfg_tindex = '0;

	// Predicted state of the unpacker.
	unpack_phase_t      unp_phase = PH_HEADER;
	logic [3:0]         hdr_count = '0;
	logic [63:0]        shift_reg = '0;
	logic [2:0]         lane_count = '0;
	logic [31:0]        hdr_rows = '0;
	logic [31:0]        hdr_cols = '0;
	logic               hdr_transposed = 1'b0;
	logic [CW-1:0]      org_row = '0;
	logic [CW-1:0]      org_col = '0;
	logic [31:0]        cur_row = '0;
	logic [31:0]        cur_col = '0;

	tile_result_t expected_results[$];
	logic [7:0]   payload[$];

	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned long_hold_cycles = 0;
	bit          src_gaps = 1'b0;
	bit          sink_gaps = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_byte(logic [7:0] b);
		payload.insert(payload.size(), b);
	endfunction

	function automatic void expect_item(tile_result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Origin and edge-clipped extent of the configured tile.
	function automatic void tile_geometry(output longint unsigned rs, output longint unsigned cs,
		output longint unsigned er, output longint unsigned ec);
		longint unsigned ts, nbc, br, bc;
		ts = (cfg_tsize == 0) ? 1 : cfg_tsize;
		nbc = (cfg_cols + ts - 1) / ts;
		br = 0;
		bc = 0;
		if (nbc != 0) begin
			br = cfg_tindex / nbc;
			bc = cfg_tindex % nbc;
		end
		rs = br * ts;
		cs = bc * ts;
		er = (cfg_rows > rs) ? ((ts < cfg_rows - rs) ? ts : cfg_rows - rs) : 0;
		ec = (cfg_cols > cs) ? ((ts < cfg_cols - cs) ? ts : cfg_cols - cs) : 0;
	endfunction

	function automatic void flag_error(logic [KIND_W-1:0] k, bit fin);
		unp_phase = fin ? PH_HEADER : PH_DRAIN;
		hdr_count = '0;
		lane_count = '0;
		shift_reg = '0;
		expect_item(tile_result_t'{k, '0, '0, '0, 1'b1});
	endfunction

	function automatic void predict_byte(logic [7:0] b, bit fin);
		longint unsigned rs, cs, er, ec;
		logic [63:0] word;
		bit last;
		case (unp_phase)
			PH_HEADER: begin
				if (hdr_count < 4)
					hdr_rows[8 * hdr_count +: 8] = b;
				else if (hdr_count < 8)
					hdr_cols[8 * (hdr_count - 4) +: 8] = b;
				else
					hdr_transposed = (b != 0);
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= HDR_BYTES) begin
					hdr_count = '0;
					tile_geometry(rs, cs, er, ec);
					// Non-positive counts are reported before any mismatch.
					if (hdr_rows == 0 || hdr_rows[31] || hdr_cols == 0 || hdr_cols[31])
						flag_error(KIND_BAD_DIMS, fin);
					else if (hdr_rows != er || hdr_cols != ec)
						flag_error(KIND_MISMATCH, fin);
					else if (fin)
						flag_error(KIND_TRUNC, 1'b1);
					else begin
						org_row = rs[CW-1:0];
						org_col = cs[CW-1:0];
						cur_row = '0;
						cur_col = '0;
						shift_reg = '0;
						lane_count = '0;
						unp_phase = PH_DATA;
					end
				end else if (fin) begin
					flag_error(KIND_TRUNC, 1'b1);
				end
			end
			PH_DATA: begin
				shift_reg |= 64'(b) << (8 * lane_count);
				lane_count = lane_count + 3'd1;
				if (lane_count != 0) begin
					if (fin)
						flag_error(KIND_TRUNC, 1'b1);
				end else begin
					word = shift_reg;
					shift_reg = '0;
					last = (cur_row + 32'd1 >= hdr_rows) && (cur_col + 32'd1 >= hdr_cols);
					// A final byte on an element other than the last replaces it.
					if (fin && !last)
						flag_error(KIND_TRUNC, 1'b1);
					else begin
						expect_item(tile_result_t'{KIND_ELEM, org_row + cur_row,
							org_col + cur_col, word, last});
						if (last)
							unp_phase = fin ? PH_HEADER : PH_DRAIN;
						else if (hdr_transposed) begin
							if (cur_col + 32'd1 >= hdr_cols) begin
								cur_col = '0;
								cur_row++;
							end else
								cur_col++;
						end else begin
							if (cur_row + 32'd1 >= hdr_rows) begin
								cur_row = '0;
								cur_col++;
							end else
								cur_row++;
						end
					end
				end
			end
			default: begin
				if (fin) begin
					unp_phase = PH_HEADER;
					hdr_count = '0;
				end
			end
		endcase
	endfunction

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_word32(logic [31:0] w);
		for (int i = 0; i < 4; i++)
			add_byte(w[8 * i +: 8]);
	endfunction

	function automatic void add_header(logic [31:0] rows, logic [31:0] cols, logic [7:0] tr);
		add_word32(rows);
		add_word32(cols);
		add_byte(tr);
	endfunction

	function automatic void add_value(logic [63:0] v);
		add_word32(v[31:0]);
		add_word32(v[63:32]);
	endfunction

	function automatic void add_elements(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			add_value({$urandom, $urandom});
	endfunction

	function automatic logic [7:0] transpose_byte();
		case ($urandom_range(0, 3))
			0, 1: return 8'd0;
			2: return 8'd1;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [31:0] random_dim(longint unsigned near);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'(near);
			2: return 32'(near + 1);
			3: return 32'h8000_0000 | $urandom;
			4: return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	// Entered and left at a falling edge; valid stays up between back-to-back items.
	task automatic send_byte(logic [7:0] b, bit fin);
		int unsigned gap;
		gap = src_gaps ? gap_len() : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.final_byte <= fin;
		do @(posedge clk); while (!in_ch.ready);
		predict_byte(b, fin);
		@(negedge clk);
	endtask

	task automatic send_payload(int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_byte(payload[i], i == count - 1);
		payload.delete();
	endtask

	// Stops the sender until every predicted item has come out, then lets the block settle.
	task automatic drain_results();
		int unsigned waited;
		in_ch.valid <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			fail_count++;
			expected_results.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_MATRIX_ROWS: cfg_rows = data;
			REG_MATRIX_COLS: cfg_cols = data;
			REG_TILE_SIZE:   cfg_tsize = data[TS_W-1:0];
			REG_TILE_INDEX:  cfg_tindex = data[TIDX_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_geometry(logic [MDIM_W-1:0] rows, logic [MDIM_W-1:0] cols,
		logic [TS_W-1:0] ts, logic [TIDX_W-1:0] idx);
		cfg_write(REG_MATRIX_ROWS, rows);
		cfg_write(REG_MATRIX_COLS, cols);
		cfg_write(REG_TILE_SIZE, CFG_DATA_W'(ts));
		cfg_write(REG_TILE_INDEX, CFG_DATA_W'(idx));
	endtask

	// A matching header ending on a final byte gives a truncation item, anything else a
	// mismatch, so the block's tile geometry is checked without streaming elements.
	task automatic probe_geometry();
		longint unsigned rs, cs, er, ec;
		tile_geometry(rs, cs, er, ec);
		if (er == 0 || ec == 0)
			add_header(32'd1, 32'd1, 8'd0);
		else
			add_header(32'(er), 32'(ec), 8'd0);
		send_payload(payload.size());
	endtask

	task automatic test_reset_defaults();
		add_header(32'd1, 32'd1, 8'd0);
		add_value(64'hFFFF_FFFF_FFFF_FFFF);
		send_payload(payload.size());
		add_header(32'd1, 32'd1, 8'd0);
		add_value(64'd0);
		send_payload(payload.size());
	endtask

	task automatic test_header_checks();
		add_byte(8'hA5);
		send_payload(1);
		add_header(32'd0, 32'd1, 8'd0);
		send_payload(payload.size());
		// A bad header without its final byte swallows the bytes up to the final one.
		add_header(32'h8000_0000, 32'd1, 8'd0);
		add_byte(8'h00);
		add_byte(8'hFF);
		send_payload(payload.size());
		add_header(32'd1, 32'hFFFF_FFFF, 8'd0);
		send_payload(payload.size());
		add_header(32'd1, 32'd2, 8'd0);
		send_payload(payload.size());
		add_header(32'd1, 32'd1, 8'd0);
		send_payload(payload.size());
		drain_results();
	endtask

	task automatic test_geometry_corners();
		set_geometry(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF);
		probe_geometry();
		drain_results();
		set_geometry(40'd1, 40'hFF_FFFF_FFFF, 16'hFFFF, 31'd16777472);
		probe_geometry();
		drain_results();
		// With no column tiles every header mismatches.
		set_geometry(40'd5, 40'd0, 16'd2, 31'd3);
		probe_geometry();
		drain_results();
		set_geometry(40'd3, 40'd3, 16'd0, 31'd4);
		probe_geometry();
		drain_results();
		set_geometry(40'd4, 40'd4, 16'd2, 31'd7);
		probe_geometry();
		drain_results();
		set_geometry(40'd0, 40'd4, 16'd2, 31'd1);
		probe_geometry();
		drain_results();
	endtask

	task automatic test_element_order();
		// Tile at grid position (1,1) of a 4 x 5 matrix in 2 x 2 tiles: origin (2,2).
		set_geometry(40'd4, 40'd5, 16'd2, 31'd4);
		add_header(32'd2, 32'd2, 8'd0);
		add_elements(4);
		add_byte(8'h11);
		add_byte(8'h22);
		add_byte(8'h33);
		send_payload(payload.size());
		add_header(32'd2, 32'd2, 8'h80);
		add_elements(4);
		send_payload(payload.size());
		add_header(32'd2, 32'd2, 8'd1);
		add_elements(2);
		send_payload(HDR_BYTES + 11);
		add_header(32'd2, 32'd2, 8'd0);
		add_elements(2);
		send_payload(HDR_BYTES + 16);
		drain_results();
	endtask

	task automatic test_backpressure();
		long_hold_cycles = 400;
		add_header(32'd2, 32'd2, 8'd0);
		add_elements(4);
		send_payload(payload.size());
		drain_results();
	endtask

	task automatic test_random_stream();
		int unsigned done_items, pick, cut, n;
		longint unsigned rs, cs, er, ec, ts, eff, nbc, nbr, br, bc, rrem, crem;
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				src_gaps = $urandom_range(0, 2) != 0;
				sink_gaps = $urandom_range(0, 2) != 0;
			end
			if ($urandom_range(0, 2) == 0) begin
				drain_results();
				if ($urandom_range(0, 9) == 0) begin
					set_geometry(40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
						16'($urandom), 31'($urandom));
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 55)
						ts = $urandom_range(1, 4);
					else if (pick < 70)
						ts = 65535;
					else if (pick < 80)
						ts = 0;
					else
						ts = $urandom_range(5, 65534);
					eff = (ts == 0) ? 1 : ts;
					nbc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1 << 20)
						: $urandom_range(1, 6);
					nbr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1 << 10)
						: $urandom_range(1, 6);
					// Small tiles may sit anywhere; large ones only at the clipped corner.
					if (eff <= 3) begin
						br = $urandom_range(0, nbr - 1);
						bc = $urandom_range(0, nbc - 1);
						rrem = $urandom_range(1, eff);
						crem = $urandom_range(1, eff);
					end else begin
						br = nbr - 1;
						bc = nbc - 1;
						rrem = $urandom_range(1, 3);
						crem = $urandom_range(1, 3);
					end
					set_geometry((nbr - 1) * eff + rrem, (nbc - 1) * eff + crem, ts,
						br * nbc + bc);
				end
			end
			tile_geometry(rs, cs, er, ec);
			n = (er * ec <= 16) ? er * ec : 2;
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				add_header(32'(er), 32'(ec), transpose_byte());
				add_elements(n);
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 6))
						add_byte(8'($urandom));
				end
				done_items += payload.size();
				send_payload(payload.size());
			end else if (pick < 77) begin
				add_header(32'(er), 32'(ec), transpose_byte());
				add_elements(n);
				cut = $urandom_range(1, payload.size() - 1);
				done_items += cut;
				send_payload(cut);
			end else if (pick < 89) begin
				add_header(random_dim(er), random_dim(ec), transpose_byte());
				add_elements($urandom_range(0, 2));
				done_items += payload.size();
				send_payload(payload.size());
			end else begin
				cut = $urandom_range(1, 30);
				for (int unsigned i = 0; i < cut; i++)
					send_byte(8'($urandom), i == cut - 1 || $urandom_range(0, 7) == 0);
				done_items += cut;
			end
		end
		drain_results();
	endtask

	// Result side: random stalls plus one long hold-off requested by the backpressure test.
	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_cycles != 0) begin
				hold = long_hold_cycles;
				long_hold_cycles = 0;
			end
			if (hold != 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else begin
				out_ch.ready <= 1'b1;
				if (sink_gaps && $urandom_range(0, 3) == 0)
					hold = gap_len();
			end
		end
	end

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		tile_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: kind %0d row %0d col %0d value %h", $time,
					out_ch.kind, out_ch.row_index, out_ch.col_index, out_ch.value_bits);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				compare_field("kind", 64'(exp_r.kind), 64'(out_ch.kind));
				compare_field("row_index", 64'(exp_r.row), 64'(out_ch.row_index));
				compare_field("col_index", 64'(exp_r.col), 64'(out_ch.col_index));
				compare_field("value_bits", exp_r.value, out_ch.value_bits);
				compare_field("tile_end", 64'(exp_r.tile_end), 64'(out_ch.tile_end));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < WATCHDOG_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run exceeded %0d cycles", $time, WATCHDOG_LIMIT);
		$display("** block_matrix_partition_unpacker: FAILED **");
		$finish;
	end

	initial begin : stimulus
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.final_byte = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		test_reset_defaults();
		test_header_checks();
		test_geometry_corners();
		test_element_order();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		test_backpressure();
		test_random_stream();
		if (fail_count == 0)
			$display("** block_matrix_partition_unpacker: PASSED **");
		else
			$display("** block_matrix_partition_unpacker: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bmpu_pkg.sv
hw/rtl/bmpu_ifs.sv
hw/rtl/bmpu_div.sv
hw/rtl/bmpu_dp.sv
hw/rtl/bmpu_ctrl.sv
hw/rtl/block_matrix_partition_unpacker.sv
tb/block_matrix_partition_unpacker_test.sv
